FILE: design/event_frame_decoder_crc16_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the event frame decoder
// Shared helpers for concurrent checks on the core clock and reset.
// ----------------------------------------------------------------------------
`ifndef EVENT_FRAME_DECODER_CRC16_CORE_MACROS_SVH
`define EVENT_FRAME_DECODER_CRC16_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EFDCRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EFDCRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/efdcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efdcrc_pkg
// Types and constants shared by the framed event decoder.
// ----------------------------------------------------------------------------
package efdcrc_pkg;

  // CRC16-CCITT, no reflection, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  // Configuration register indexes
  localparam logic [1:0] REG_HEADER_FIRST     = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND    = 2'd1;
  localparam logic [1:0] REG_PROTOCOL_VERSION = 2'd2;
  localparam logic [1:0] REG_PAYLOAD_LIMIT    = 2'd3;

  localparam logic [7:0] RST_HEADER_FIRST     = 8'hAA;
  localparam logic [7:0] RST_HEADER_SECOND    = 8'h55;
  localparam logic [7:0] RST_PROTOCOL_VERSION = 8'h01;
  localparam logic [7:0] RST_PAYLOAD_LIMIT    = 8'd64;

  // Frame field positions
  localparam logic [3:0] POS_SYNC0    = 4'd0;
  localparam logic [3:0] POS_SYNC1    = 4'd1;
  localparam logic [3:0] POS_VERSION  = 4'd2;
  localparam logic [3:0] POS_EVENT    = 4'd3;
  localparam logic [3:0] POS_RISK     = 4'd4;
  localparam logic [3:0] POS_CONF     = 4'd5;
  localparam logic [3:0] POS_DUR_HI   = 4'd6;
  localparam logic [3:0] POS_DUR_LO   = 4'd7;
  localparam logic [3:0] POS_TS0      = 4'd8;
  localparam logic [3:0] POS_TS1      = 4'd9;
  localparam logic [3:0] POS_TS2      = 4'd10;
  localparam logic [3:0] POS_TS3      = 4'd11;
  localparam logic [3:0] POS_LENGTH   = 4'd12;
  localparam logic [3:0] POS_PAYLOAD  = 4'd13;
  localparam logic [3:0] POS_CRC_HI   = 4'd14;
  localparam logic [3:0] POS_CRC_LO   = 4'd15;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_HDR   = 3'd1;
  localparam logic [2:0] STAT_BAD_VER   = 3'd2;
  localparam logic [2:0] STAT_TOO_LONG  = 3'd3;
  localparam logic [2:0] STAT_TOO_SHORT = 3'd4;
  localparam logic [2:0] STAT_CRC_ERR   = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  event_code;
    logic [7:0]  risk;
    logic [7:0]  confidence;
    logic [15:0] duration;
    logic [31:0] time_stamp;
    logic [7:0]  payload_length;
  } out_beat_t;

endpackage

FILE: design/efdcrc_crc_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efdcrc_crc_byte
// One-byte CRC16-CCITT update, MSB first, eight steps unrolled.
// ----------------------------------------------------------------------------
module efdcrc_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & efdcrc_pkg::CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ efdcrc_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

FILE: design/event_frame_decoder_crc16_core.sv
`timescale 1ns / 1ps
// A beat's result is registered in the output register, or in the skid register
// if the output stalls. Throughput: one byte per cycle while in_ready is high;
// parsing and CRC update are combinational between state and output registers.
// in_ready drops only while the skid register holds a second waiting result.
// Reset (synchronous, rst_n low): config to defaults, parser at first sync byte.
// ----------------------------------------------------------------------------
// event_frame_decoder_crc16_core
// Streaming framed event decoder with CRC16-CCITT check and payload pass-out.
// ----------------------------------------------------------------------------
`include "event_frame_decoder_crc16_core_macros.svh"

module event_frame_decoder_crc16_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  efdcrc_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output efdcrc_pkg::out_beat_t out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  // configuration
  logic [7:0] hdr_first_r, hdr_second_r, version_r, limit_r;

  // parser state
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  remaining_r, remaining_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  event_r, event_nxt;
  logic [7:0]  risk_r, risk_nxt;
  logic [7:0]  conf_r, conf_nxt;
  logic [15:0] dur_r, dur_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic        discarding_r, discarding_nxt;

  // output register plus skid
  logic                  out_valid_r, skid_valid_r;
  efdcrc_pkg::out_beat_t out_data_r, skid_data_r;

  logic                  in_fire, out_fire;
  logic                  has_result, restart, verdict_hit, emit;
  logic [2:0]            verdict_code;
  efdcrc_pkg::out_beat_t result;
  logic [15:0]           crc_upd;
  logic [7:0]            b;
  logic                  last;
  logic                  end_fire, frame_clean, at_payload;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = in_data.rx_byte;
  assign last      = in_data.buffer_end;

  efdcrc_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (b),
    .crc_out (crc_upd)
  );

  always_comb begin
    pos_nxt        = pos_r;
    remaining_nxt  = remaining_r;
    crc_nxt        = crc_r;
    event_nxt      = event_r;
    risk_nxt       = risk_r;
    conf_nxt       = conf_r;
    dur_nxt        = dur_r;
    ts_nxt         = ts_r;
    length_nxt     = length_r;
    crc_hi_nxt     = crc_hi_r;
    discarding_nxt = discarding_r;
    has_result     = 1'b0;
    restart        = 1'b0;
    verdict_hit    = 1'b0;
    verdict_code   = efdcrc_pkg::STAT_OK;
    emit           = 1'b0;
    result         = '0;

    if (in_fire) begin
      if (discarding_r) begin
        // drop everything up to and including the end-flagged byte
        restart = last;
      end else begin
        if (pos_r < efdcrc_pkg::POS_CRC_HI) begin
          crc_nxt = crc_upd;
        end
        unique case (pos_r) inside
          efdcrc_pkg::POS_SYNC0: begin
            if (b != hdr_first_r) begin
              verdict_hit  = 1'b1;
              verdict_code = efdcrc_pkg::STAT_BAD_HDR;
            end else begin
              pos_nxt = efdcrc_pkg::POS_SYNC1;
            end
          end
          efdcrc_pkg::POS_SYNC1: begin
            if (b != hdr_second_r) begin
              verdict_hit  = 1'b1;
              verdict_code = efdcrc_pkg::STAT_BAD_HDR;
            end else begin
              pos_nxt = efdcrc_pkg::POS_VERSION;
            end
          end
          efdcrc_pkg::POS_VERSION: begin
            if (b != version_r) begin
              verdict_hit  = 1'b1;
              verdict_code = efdcrc_pkg::STAT_BAD_VER;
            end else begin
              pos_nxt = efdcrc_pkg::POS_EVENT;
            end
          end
          efdcrc_pkg::POS_EVENT: begin
            event_nxt = b;
            pos_nxt   = efdcrc_pkg::POS_RISK;
          end
          efdcrc_pkg::POS_RISK: begin
            risk_nxt = b;
            pos_nxt  = efdcrc_pkg::POS_CONF;
          end
          efdcrc_pkg::POS_CONF: begin
            conf_nxt = b;
            pos_nxt  = efdcrc_pkg::POS_DUR_HI;
          end
          efdcrc_pkg::POS_DUR_HI: begin
            dur_nxt = {b, 8'h00};
            pos_nxt = efdcrc_pkg::POS_DUR_LO;
          end
          efdcrc_pkg::POS_DUR_LO: begin
            dur_nxt = {dur_r[15:8], b};
            pos_nxt = efdcrc_pkg::POS_TS0;
          end
          efdcrc_pkg::POS_TS0, efdcrc_pkg::POS_TS1,
          efdcrc_pkg::POS_TS2, efdcrc_pkg::POS_TS3: begin
            ts_nxt  = {ts_r[23:0], b};
            pos_nxt = pos_r + 4'd1;
          end
          efdcrc_pkg::POS_LENGTH: begin
            length_nxt = b;
            if (b > limit_r) begin
              verdict_hit  = 1'b1;
              verdict_code = efdcrc_pkg::STAT_TOO_LONG;
            end else begin
              remaining_nxt = b;
              pos_nxt = (b != 8'd0) ? efdcrc_pkg::POS_PAYLOAD : efdcrc_pkg::POS_CRC_HI;
            end
          end
          efdcrc_pkg::POS_PAYLOAD: begin
            emit          = 1'b1;
            remaining_nxt = remaining_r - 8'd1;
            if (remaining_nxt == 8'd0) begin
              pos_nxt = efdcrc_pkg::POS_CRC_HI;
            end
          end
          efdcrc_pkg::POS_CRC_HI: begin
            crc_hi_nxt = b;
            pos_nxt    = efdcrc_pkg::POS_CRC_LO;
          end
          default: begin
            verdict_hit  = 1'b1;
            verdict_code = ({crc_hi_r, b} == crc_r) ? efdcrc_pkg::STAT_OK
                                                    : efdcrc_pkg::STAT_CRC_ERR;
          end
        endcase

        // buffer ran out before the frame closed
        if (!verdict_hit && last) begin
          verdict_hit  = 1'b1;
          verdict_code = efdcrc_pkg::STAT_TOO_SHORT;
        end

        if (verdict_hit) begin
          has_result            = 1'b1;
          result.kind           = efdcrc_pkg::KIND_VERDICT;
          result.status         = verdict_code;
          result.event_code     = event_nxt;
          result.risk           = risk_nxt;
          result.confidence     = conf_nxt;
          result.duration       = dur_nxt;
          result.time_stamp     = ts_nxt;
          result.payload_length = length_nxt;
          restart               = last;
          discarding_nxt        = !last;
        end else if (emit) begin
          has_result          = 1'b1;
          result.kind         = efdcrc_pkg::KIND_PAYLOAD;
          result.payload_byte = b;
        end
      end
    end

    if (restart) begin
      pos_nxt        = efdcrc_pkg::POS_SYNC0;
      remaining_nxt  = 8'd0;
      crc_nxt        = efdcrc_pkg::CRC_INIT;
      event_nxt      = 8'd0;
      risk_nxt       = 8'd0;
      conf_nxt       = 8'd0;
      dur_nxt        = 16'd0;
      ts_nxt         = 32'd0;
      length_nxt     = 8'd0;
      crc_hi_nxt     = 8'd0;
      discarding_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= efdcrc_pkg::RST_HEADER_FIRST;
      hdr_second_r <= efdcrc_pkg::RST_HEADER_SECOND;
      version_r    <= efdcrc_pkg::RST_PROTOCOL_VERSION;
      limit_r      <= efdcrc_pkg::RST_PAYLOAD_LIMIT;
      pos_r        <= efdcrc_pkg::POS_SYNC0;
      remaining_r  <= 8'd0;
      crc_r        <= efdcrc_pkg::CRC_INIT;
      event_r      <= 8'd0;
      risk_r       <= 8'd0;
      conf_r       <= 8'd0;
      dur_r        <= 16'd0;
      ts_r         <= 32'd0;
      length_r     <= 8'd0;
      crc_hi_r     <= 8'd0;
      discarding_r <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          efdcrc_pkg::REG_HEADER_FIRST:     hdr_first_r  <= cfg_data;
          efdcrc_pkg::REG_HEADER_SECOND:    hdr_second_r <= cfg_data;
          efdcrc_pkg::REG_PROTOCOL_VERSION: version_r    <= cfg_data;
          efdcrc_pkg::REG_PAYLOAD_LIMIT:    limit_r      <= cfg_data;
          default: ;
        endcase
      end
      pos_r        <= pos_nxt;
      remaining_r  <= remaining_nxt;
      crc_r        <= crc_nxt;
      event_r      <= event_nxt;
      risk_r       <= risk_nxt;
      conf_r       <= conf_nxt;
      dur_r        <= dur_nxt;
      ts_r         <= ts_nxt;
      length_r     <= length_nxt;
      crc_hi_r     <= crc_hi_nxt;
      discarding_r <= discarding_nxt;

      if (skid_valid_r) begin
        // advance the skid beat once the output beat leaves
        if (out_fire) begin
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end
      end else if (has_result) begin
        if (!out_valid_r || out_fire) begin
          out_data_r  <= result;
          out_valid_r <= 1'b1;
        end else begin
          skid_data_r  <= result;
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign end_fire    = in_fire && last;
  assign frame_clean = (pos_r == efdcrc_pkg::POS_SYNC0) && !discarding_r
                       && (crc_r == efdcrc_pkg::CRC_INIT);
  assign at_payload  = (pos_r == efdcrc_pkg::POS_PAYLOAD);

  `EFDCRC_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid beat without output beat")
  `EFDCRC_ASSERT_NOW(a_payload_count, at_payload, remaining_r != 8'd0, "empty payload count")
  `EFDCRC_ASSERT_NEXT(a_end_restarts, end_fire, frame_clean, "end beat did not restart frame")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed event decoder testbench
// Drives byte streams of well-formed, corrupted, truncated and noisy frames
// into the decoder under changing register settings and back-pressure. A
// bit-accurate parser tracks every accepted byte, and the result beats are
// compared field by field, in order, against what it predicts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 600000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  efdcrc_pkg::in_beat_t  in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [1:0]            cfg_index = efdcrc_pkg::REG_HEADER_FIRST;
  logic [7:0]            cfg_data  = 8'h00;
  logic                  in_ready;
  logic                  out_valid;
  efdcrc_pkg::out_beat_t out_data;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count = 0;

  // register shadow
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [7:0] version_req;
  logic [7:0] length_cap;

  // parser shadow
  logic [3:0]  frame_pos;
  logic [7:0]  bytes_left;
  logic [15:0] crc_acc;
  logic [7:0]  got_event;
  logic [7:0]  got_risk;
  logic [7:0]  got_conf;
  logic [15:0] got_duration;
  logic [31:0] got_stamp;
  logic [7:0]  got_length;
  logic [7:0]  crc_high_seen;
  logic        dropping;

  efdcrc_pkg::out_beat_t decoded_beats[$];
  logic [7:0]            frame_buf[$];

  event_frame_decoder_crc16_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    int i;
    acc = crc ^ {data, 8'h00};
    for (i = 0; i < 8; i++) begin
      if ((acc & efdcrc_pkg::CRC_MSB) != 16'h0000) acc = (acc << 1) ^ efdcrc_pkg::CRC_POLY;
      else acc = acc << 1;
    end
    return acc;
  endfunction

  function automatic void restart_frame();
    frame_pos     = efdcrc_pkg::POS_SYNC0;
    bytes_left    = 8'h00;
    crc_acc       = efdcrc_pkg::CRC_INIT;
    got_event     = 8'h00;
    got_risk      = 8'h00;
    got_conf      = 8'h00;
    got_duration  = 16'h0000;
    got_stamp     = 32'h0;
    got_length    = 8'h00;
    crc_high_seen = 8'h00;
    dropping      = 1'b0;
  endfunction

  // Advance the parser by one accepted byte and queue the beat it produces.
  function automatic void parse_rx_byte(input efdcrc_pkg::in_beat_t beat);
    logic [7:0]            b;
    logic                  has_verdict;
    logic [2:0]            verdict;
    logic                  emit_byte;
    efdcrc_pkg::out_beat_t res;
    b = beat.rx_byte;
    has_verdict = 1'b0;
    verdict = efdcrc_pkg::STAT_OK;
    emit_byte = 1'b0;
    res = '0;
    if (dropping) begin
      if (beat.buffer_end) restart_frame();
      return;
    end
    if (frame_pos < efdcrc_pkg::POS_CRC_HI) crc_acc = crc16_next(crc_acc, b);
    case (frame_pos)
      efdcrc_pkg::POS_SYNC0: begin
        if (b != sync_first) begin
          has_verdict = 1'b1;
          verdict = efdcrc_pkg::STAT_BAD_HDR;
        end else frame_pos = efdcrc_pkg::POS_SYNC1;
      end
      efdcrc_pkg::POS_SYNC1: begin
        if (b != sync_second) begin
          has_verdict = 1'b1;
          verdict = efdcrc_pkg::STAT_BAD_HDR;
        end else frame_pos = efdcrc_pkg::POS_VERSION;
      end
      efdcrc_pkg::POS_VERSION: begin
        if (b != version_req) begin
          has_verdict = 1'b1;
          verdict = efdcrc_pkg::STAT_BAD_VER;
        end else frame_pos = efdcrc_pkg::POS_EVENT;
      end
      efdcrc_pkg::POS_EVENT: begin got_event = b; frame_pos = efdcrc_pkg::POS_RISK; end
      efdcrc_pkg::POS_RISK: begin got_risk = b; frame_pos = efdcrc_pkg::POS_CONF; end
      efdcrc_pkg::POS_CONF: begin got_conf = b; frame_pos = efdcrc_pkg::POS_DUR_HI; end
      efdcrc_pkg::POS_DUR_HI: begin
        got_duration = {b, 8'h00};
        frame_pos = efdcrc_pkg::POS_DUR_LO;
      end
      efdcrc_pkg::POS_DUR_LO: begin
        got_duration[7:0] = b;
        frame_pos = efdcrc_pkg::POS_TS0;
      end
      efdcrc_pkg::POS_TS0, efdcrc_pkg::POS_TS1, efdcrc_pkg::POS_TS2,
      efdcrc_pkg::POS_TS3: begin
        got_stamp = {got_stamp[23:0], b};
        frame_pos = frame_pos + 4'd1;
      end
      efdcrc_pkg::POS_LENGTH: begin
        got_length = b;
        if (b > length_cap) begin
          has_verdict = 1'b1;
          verdict = efdcrc_pkg::STAT_TOO_LONG;
        end else begin
          bytes_left = b;
          frame_pos = (b != 8'h00) ? efdcrc_pkg::POS_PAYLOAD : efdcrc_pkg::POS_CRC_HI;
        end
      end
      efdcrc_pkg::POS_PAYLOAD: begin
        emit_byte = 1'b1;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) frame_pos = efdcrc_pkg::POS_CRC_HI;
      end
      efdcrc_pkg::POS_CRC_HI: begin
        crc_high_seen = b;
        frame_pos = efdcrc_pkg::POS_CRC_LO;
      end
      efdcrc_pkg::POS_CRC_LO: begin
        has_verdict = 1'b1;
        verdict = ({crc_high_seen, b} == crc_acc) ? efdcrc_pkg::STAT_OK
                                                  : efdcrc_pkg::STAT_CRC_ERR;
      end
      default: ;
    endcase
    // end of buffer before the frame completes overrides a payload byte
    if (!has_verdict && beat.buffer_end) begin
      has_verdict = 1'b1;
      verdict = efdcrc_pkg::STAT_TOO_SHORT;
    end
    if (has_verdict) begin
      res.kind           = efdcrc_pkg::KIND_VERDICT;
      res.status         = verdict;
      res.event_code     = got_event;
      res.risk           = got_risk;
      res.confidence     = got_conf;
      res.duration       = got_duration;
      res.time_stamp     = got_stamp;
      res.payload_length = got_length;
      decoded_beats.push_back(res);
      if (beat.buffer_end) restart_frame();
      else dropping = 1'b1;
    end else if (emit_byte) begin
      res.kind = efdcrc_pkg::KIND_PAYLOAD;
      res.payload_byte = b;
      decoded_beats.push_back(res);
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_output(input efdcrc_pkg::out_beat_t got);
    efdcrc_pkg::out_beat_t want;
    if (decoded_beats.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing pending, kind %0d", got.kind));
      return;
    end
    want = decoded_beats.pop_front();
    check_field("kind", 32'(got.kind), 32'(want.kind));
    check_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
    check_field("status", 32'(got.status), 32'(want.status));
    check_field("event_code", 32'(got.event_code), 32'(want.event_code));
    check_field("risk", 32'(got.risk), 32'(want.risk));
    check_field("confidence", 32'(got.confidence), 32'(want.confidence));
    check_field("duration", 32'(got.duration), 32'(want.duration));
    check_field("time_stamp", got.time_stamp, want.time_stamp);
    check_field("payload_length", 32'(got.payload_length), 32'(want.payload_length));
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) check_output(out_data);
  end

  task automatic send_beat(input logic [7:0] data, input logic end_flag);
    efdcrc_pkg::in_beat_t beat;
    beat.rx_byte = data;
    beat.buffer_end = end_flag;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_rx_byte(beat);
  endtask

  // Flag the last byte; optionally sprinkle extra end flags in between.
  task automatic send_buffer(input bit scatter_ends);
    int k;
    logic end_flag;
    for (k = 0; k < frame_buf.size(); k++) begin
      end_flag = (k == frame_buf.size() - 1) || (scatter_ends && $urandom_range(3) == 0);
      send_beat(frame_buf[k], end_flag);
    end
  endtask

  // Hold the input low until every pending beat is out and the pipe is quiet.
  task automatic drain_decoder();
    in_valid <= 1'b0;
    while (decoded_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      efdcrc_pkg::REG_HEADER_FIRST:     sync_first  = value;
      efdcrc_pkg::REG_HEADER_SECOND:    sync_second = value;
      efdcrc_pkg::REG_PROTOCOL_VERSION: version_req = value;
      efdcrc_pkg::REG_PAYLOAD_LIMIT:    length_cap  = value;
      default: ;
    endcase
  endtask

  task automatic program_registers(input logic [7:0] first, input logic [7:0] second,
                                   input logic [7:0] version, input logic [7:0] cap);
    drain_decoder();
    write_reg(efdcrc_pkg::REG_HEADER_FIRST, first);
    write_reg(efdcrc_pkg::REG_HEADER_SECOND, second);
    write_reg(efdcrc_pkg::REG_PROTOCOL_VERSION, version);
    write_reg(efdcrc_pkg::REG_PAYLOAD_LIMIT, cap);
    cfg_we <= 1'b0;
  endtask

  task automatic program_random_registers();
    logic [7:0] cap;
    cap = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(32));
    program_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), cap);
  endtask

  function automatic void reseal_crc();
    logic [15:0] crc;
    int k;
    crc = efdcrc_pkg::CRC_INIT;
    for (k = 0; k < frame_buf.size() - 2; k++) crc = crc16_next(crc, frame_buf[k]);
    frame_buf[frame_buf.size() - 2] = crc[15:8];
    frame_buf[frame_buf.size() - 1] = crc[7:0];
  endfunction

  function automatic void build_frame(input logic [7:0] plen);
    frame_buf.delete();
    frame_buf.push_back(sync_first);
    frame_buf.push_back(sync_second);
    frame_buf.push_back(version_req);
    repeat (9) frame_buf.push_back(8'($urandom_range(255)));
    frame_buf.push_back(plen);
    repeat (plen) frame_buf.push_back(8'($urandom_range(255)));
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    reseal_crc();
  endfunction

  // Set event through timestamp to one value and refresh the CRC.
  function automatic void fill_fields(input logic [7:0] value);
    int k;
    for (k = 3; k < 12; k++) frame_buf[k] = value;
    reseal_crc();
  endfunction

  function automatic void cut_buffer(input int keep);
    while (frame_buf.size() > keep) void'(frame_buf.pop_back());
  endfunction

  function automatic logic [7:0] pick_length();
    int roll;
    int cap;
    roll = $urandom_range(99);
    cap = (length_cap < 8'd8) ? int'(length_cap) : 8;
    if (roll < 5) return length_cap;
    if (roll < 8) return 8'($urandom_range(length_cap));
    return 8'($urandom_range(cap));
  endfunction

  task automatic test_frame_verdicts();
    build_frame(8'd0);
    fill_fields(8'h00);
    send_buffer(1'b0);
    build_frame(8'd2);
    frame_buf[13] = 8'hFF;
    frame_buf[14] = 8'h00;
    fill_fields(8'hFF);
    send_buffer(1'b0);
    // wrong first sync byte, then wrong second sync byte
    frame_buf.delete();
    frame_buf.push_back(~sync_first);
    send_buffer(1'b0);
    frame_buf.delete();
    frame_buf.push_back(sync_first);
    frame_buf.push_back(~sync_second);
    send_buffer(1'b0);
    // wrong version, trailing byte dropped
    frame_buf.delete();
    frame_buf.push_back(sync_first);
    frame_buf.push_back(sync_second);
    frame_buf.push_back(version_req ^ 8'h80);
    frame_buf.push_back(8'h3C);
    send_buffer(1'b0);
    // length one above the limit
    build_frame(8'd0);
    frame_buf[12] = length_cap + 8'd1;
    cut_buffer(13);
    send_buffer(1'b0);
    // buffer ends inside the fields
    build_frame(8'd0);
    cut_buffer(5);
    send_buffer(1'b0);
    // buffer ends on a payload byte
    build_frame(8'd3);
    cut_buffer(14);
    send_buffer(1'b0);
    // corrupted CRC
    build_frame(8'd1);
    frame_buf[frame_buf.size() - 1] ^= 8'h01;
    send_buffer(1'b0);
    // good frame without end flag, trailing bytes dropped
    build_frame(8'd1);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    send_buffer(1'b0);
  endtask

  task automatic test_register_extremes();
    program_registers(8'h00, 8'h00, 8'h00, 8'h00);
    build_frame(8'd0);
    send_buffer(1'b0);
    build_frame(8'd1);
    send_buffer(1'b0);
    program_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    build_frame(8'd255);
    send_buffer(1'b0);
    build_frame(8'd3);
    frame_buf[2] = 8'hFE;
    send_buffer(1'b0);
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    send_buffer(1'b0);
  endtask

  task automatic test_random_frames(input int byte_budget);
    int sent;
    int pick;
    int n;
    bit noisy;
    sent = 0;
    while (sent < byte_budget) begin
      build_frame(pick_length());
      noisy = 0;
      pick = $urandom_range(99);
      if (pick < 45) begin
        // clean frame
      end else if (pick < 55) begin
        repeat ($urandom_range(4, 1)) frame_buf.push_back(8'($urandom_range(255)));
      end else if (pick < 63) begin
        n = $urandom_range(frame_buf.size() - 1, 3);
        frame_buf[n] ^= 8'(1 << $urandom_range(7));
      end else if (pick < 68) begin
        frame_buf[$urandom_range(1)] ^= 8'($urandom_range(255, 1));
      end else if (pick < 73) begin
        frame_buf[2] ^= 8'($urandom_range(255, 1));
      end else if (pick < 80) begin
        if (length_cap != 8'hFF) begin
          frame_buf[12] = 8'($urandom_range(255, length_cap + 1));
          cut_buffer(13 + $urandom_range(3));
        end
      end else if (pick < 90) begin
        cut_buffer($urandom_range(frame_buf.size() - 1, 1));
      end else begin
        frame_buf.delete();
        repeat ($urandom_range(6, 1)) frame_buf.push_back(8'($urandom_range(255)));
        noisy = 1;
      end
      sent += frame_buf.size();
      send_buffer(noisy);
    end
  endtask

  initial begin
    send_idle_pct = 33;
    recv_idle_pct = 83;
    sync_first  = efdcrc_pkg::RST_HEADER_FIRST;
    sync_second = efdcrc_pkg::RST_HEADER_SECOND;
    version_req = efdcrc_pkg::RST_PROTOCOL_VERSION;
    length_cap  = efdcrc_pkg::RST_PAYLOAD_LIMIT;
    restart_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_frame_verdicts();
    test_register_extremes();
    program_registers(efdcrc_pkg::RST_HEADER_FIRST, efdcrc_pkg::RST_HEADER_SECOND,
                      efdcrc_pkg::RST_PROTOCOL_VERSION, efdcrc_pkg::RST_PAYLOAD_LIMIT);
    test_random_frames(270);
    program_random_registers();
    send_idle_pct = 83;
    recv_idle_pct = 33;
    test_random_frames(270);
    program_random_registers();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(290);
    drain_decoder();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
